/* design/vector_refraction_macros.svh */
// Assertion macros shared by the checker of vector_refraction.
// Depends on nothing.
`ifndef VECTOR_REFRACTION_MACROS_SVH
`define VECTOR_REFRACTION_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define VR_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("vector_refraction check failed");
// Next-cycle implication checked outside reset.
`define VR_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("vector_refraction check failed");
`endif

/* design/vr_pkg.sv */
// Package for vector_refraction: widths, rounding and saturation helpers.
// Used by every design file but the assertion macros.
package vr_pkg;
  localparam int FRAC_BITS = 16;
  localparam int W = 21;
  localparam int EW = 20;
  localparam int LAT = 42;  // delay from the start transfer to the result transfer

  // round to nearest, ties up, drop FRAC_BITS
  function automatic logic signed [63:0] narrow(input logic signed [63:0] v);
    logic signed [63:0] x;
    x = v + (64'sd1 <<< (FRAC_BITS - 1));
    return x >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] clampv(input logic signed [63:0] v,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction
endpackage

/* design/vr_front.sv */
// Front stages: dot product, cosine, perpendicular part p and the gap of its squared length from one.
// Depends on vr_pkg.
module vr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [vr_pkg::W-1:0]    d [3],
  input  logic signed [vr_pkg::W-1:0]    n [3],
  input  logic [vr_pkg::EW-1:0]          eta,
  output logic                           out_valid,
  output logic signed [31:0]             p_o [3],
  output logic signed [vr_pkg::W-1:0]    n_o [3],
  output logic [63:0]                    diff_o
);
  logic v1, v2, v3, v4, v5, v6, v7;
  logic signed [41:0] prod1 [3];
  logic signed [vr_pkg::W-1:0] d1 [3], n1 [3], d2 [3], n2 [3], d3 [3], n3 [3];
  logic signed [vr_pkg::W-1:0] d4 [3], n4 [3], n5 [3], n6 [3], n7 [3];
  logic [vr_pkg::EW-1:0] e1, e2, e3, e4;
  logic signed [43:0] dot2;
  logic signed [26:0] cos3;           // down to -3 * 2^24, up to 1.0
  logic signed [47:0] cprod4 [3];
  logic signed [52:0] eprod5 [3];
  logic signed [31:0] p6 [3], p7 [3];
  logic [63:0] sq7 [3];
  logic signed [63:0] cos_w, t_w [3], pn_w [3];
  logic [63:0] len_w;

  always_comb begin
    cos_w = vr_pkg::narrow(-64'(dot2));
    if (cos_w > (64'sd1 <<< vr_pkg::FRAC_BITS)) cos_w = 64'sd1 <<< vr_pkg::FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      t_w[i] = 64'(d4[i]) + vr_pkg::narrow(64'(cprod4[i]));
      pn_w[i] = vr_pkg::clampv(vr_pkg::narrow(64'(eprod5[i])),
                               -64'sd2147483648, 64'sd2147483647);
    end
    // squared length wraps modulo 2^64
    len_w = sq7[0] + sq7[1] + sq7[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      v7 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
      out_valid <= v7;
    end
    for (int i = 0; i < 3; i++) begin
      prod1[i] <= d[i] * n[i];
      d1[i] <= d[i]; n1[i] <= n[i];
      d2[i] <= d1[i]; n2[i] <= n1[i];
      d3[i] <= d2[i]; n3[i] <= n2[i];
      cprod4[i] <= cos3 * n3[i];
      d4[i] <= d3[i]; n4[i] <= n3[i];
      eprod5[i] <= $signed({1'b0, e4}) * 32'(t_w[i]);
      n5[i] <= n4[i];
      p6[i] <= 32'(pn_w[i]);
      n6[i] <= n5[i];
      sq7[i] <= 64'(p6[i] * p6[i]);
      p7[i] <= p6[i];
      n7[i] <= n6[i];
      p_o[i] <= p7[i];
      n_o[i] <= n7[i];
    end
    e1 <= eta; e2 <= e1; e3 <= e2; e4 <= e3;
    dot2 <= 44'(prod1[0]) + 44'(prod1[1]) + 44'(prod1[2]);
    cos3 <= 27'(cos_w);
    if (len_w <= (64'd1 << (2 * vr_pkg::FRAC_BITS)))
      diff_o <= (64'd1 << (2 * vr_pkg::FRAC_BITS)) - len_w;
    else
      diff_o <= len_w - (64'd1 << (2 * vr_pkg::FRAC_BITS));
  end
endmodule

/* design/vr_sqrt.sv */
// Pipelined integer square root, one result bit per stage (32 stages).
// Depends on vr_pkg.
module vr_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [63:0]                 x,
  input  logic signed [31:0]          p_i [3],
  input  logic signed [vr_pkg::W-1:0] n_i [3],
  output logic                        out_valid,
  output logic [31:0]                 s,
  output logic signed [31:0]          p_o [3],
  output logic signed [vr_pkg::W-1:0] n_o [3]
);
  logic [32:0] vld;
  logic [63:0] rem [33];
  logic [31:0] root [33];
  logic signed [31:0] pp [33][3];
  logic signed [vr_pkg::W-1:0] nn [33][3];

  assign vld[0] = in_valid;
  assign rem[0] = x;
  assign root[0] = '0;
  assign pp[0] = p_i;
  assign nn[0] = n_i;

  for (genvar k = 0; k < 32; k++) begin : g_st
    logic [65:0] trial;
    assign trial = 66'({root[k][30:0], 2'b01}) << (2 * (31 - k));
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else vld[k+1] <= vld[k];
      if (66'(rem[k]) >= trial) begin
        rem[k+1] <= rem[k] - trial[63:0];
        root[k+1] <= {root[k][30:0], 1'b1};
      end else begin
        rem[k+1] <= rem[k];
        root[k+1] <= {root[k][30:0], 1'b0};
      end
      pp[k+1] <= pp[k];
      nn[k+1] <= nn[k];
    end
  end

  assign out_valid = vld[32];
  assign s = root[32];
  assign p_o = pp[32];
  assign n_o = nn[32];
endmodule

/* design/vr_back.sv */
// Back stages: q = -round(s*n), sum with p and saturation.
// Depends on vr_pkg.
module vr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [31:0]                 s,
  input  logic signed [31:0]          p_i [3],
  input  logic signed [vr_pkg::W-1:0] n_i [3],
  output logic                        out_valid,
  output logic signed [vr_pkg::W-1:0] r [3]
);
  logic v1;
  logic signed [53:0] prod [3];
  logic signed [31:0] p1 [3];
  logic signed [63:0] sum_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      sum_w[i] = vr_pkg::clampv(64'(p1[i]) - vr_pkg::narrow(64'(prod[i])),
                                -64'sd1048576, 64'sd1048575);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; out_valid <= v1;
    end
    for (int i = 0; i < 3; i++) begin
      prod[i] <= $signed({1'b0, s}) * n_i[i];
      p1[i] <= p_i[i];
      r[i] <= vr_pkg::W'(sum_w[i]);
    end
  end
endmodule

/* design/vector_refraction.sv */
// vector_refraction: Snell refraction of one ray per clock, Q4.16 in and out.
// Fully pipelined: the result transfer follows the start transfer through 8 front
// stages, 32 root stages and 2 back stages; a new item may be started every
// cycle (busy is held low). The 32-stage square root, one root bit per stage,
// sets most of the latency.
// Results are shown for one cycle under done and cannot be held off.
// Depends on vr_pkg, vr_front, vr_sqrt, vr_back.
module vector_refraction (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [vr_pkg::W-1:0] in_dir_x,
  input  logic signed [vr_pkg::W-1:0] in_dir_y,
  input  logic signed [vr_pkg::W-1:0] in_dir_z,
  input  logic signed [vr_pkg::W-1:0] norm_x,
  input  logic signed [vr_pkg::W-1:0] norm_y,
  input  logic signed [vr_pkg::W-1:0] norm_z,
  input  logic [vr_pkg::EW-1:0]       eta_ratio,
  output logic                        done,
  output logic signed [vr_pkg::W-1:0] out_dir_x,
  output logic signed [vr_pkg::W-1:0] out_dir_y,
  output logic signed [vr_pkg::W-1:0] out_dir_z
);
  logic signed [vr_pkg::W-1:0] d [3], n [3], n_f [3], n_s [3], r [3];
  logic signed [31:0] p_f [3], p_s [3];
  logic [63:0] diff;
  logic [31:0] s;
  logic v_f, v_s;

  // the pipeline never stalls, so the block is always ready
  assign busy = 1'b0;
  assign d = '{in_dir_x, in_dir_y, in_dir_z};
  assign n = '{norm_x, norm_y, norm_z};

  vr_front u_front (.clk, .rst, .in_valid(start & ~busy), .d, .n, .eta(eta_ratio),
                    .out_valid(v_f), .p_o(p_f), .n_o(n_f), .diff_o(diff));
  vr_sqrt u_sqrt (.clk, .rst, .in_valid(v_f), .x(diff), .p_i(p_f), .n_i(n_f),
                  .out_valid(v_s), .s, .p_o(p_s), .n_o(n_s));
  vr_back u_back (.clk, .rst, .in_valid(v_s), .s, .p_i(p_s), .n_i(n_s),
                  .out_valid(done), .r);

  assign out_dir_x = r[0];
  assign out_dir_y = r[1];
  assign out_dir_z = r[2];
endmodule

/* design/vector_refraction_checker.sv */
// Port-level checker for vector_refraction, bound to the top level.
// Depends on vector_refraction_macros.svh and vr_pkg.
`include "vector_refraction_macros.svh"
module vector_refraction_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  `VR_ASSERT_IMPL(a_never_busy, 1'b1, !busy)
  `VR_ASSERT_NEXT(a_reset_quiet, $past(rst), !done || !$past(rst, 2))
  `VR_ASSERT_IMPL(a_done_follows, done && !$past(rst, vr_pkg::LAT),
                  $past(start, vr_pkg::LAT))
endmodule

bind vector_refraction vector_refraction_checker u_chk (.clk, .rst, .start, .busy, .done);

/* dv/vector_refraction_tb.sv */
// Self-checking testbench for vector_refraction: Snell refraction in Q4.16.
// Directed table followed by random rays, checked against a built-in predictor.
// Depends on vr_pkg and the vector_refraction RTL.
module vector_refraction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_RAYS = 1700;
  localparam int STALL_LIMIT = 4000;   // cycles with no transfer at all
  localparam longint ONE_Q = 64'sd1 << vr_pkg::FRAC_BITS;

  typedef struct packed {
    logic signed [vr_pkg::W-1:0] dx, dy, dz;
    logic signed [vr_pkg::W-1:0] nx, ny, nz;
    logic [vr_pkg::EW-1:0]       eta;
  } ray_t;

  typedef struct packed {
    logic signed [vr_pkg::W-1:0] rx, ry, rz;
  } dir_t;

  // directed row: ray, plus a hand-typed answer where it is obvious
  typedef struct packed {
    ray_t ray;
    logic known;
    dir_t want;
  } row_t;

  logic clk, rst, start, busy, done;
  logic signed [vr_pkg::W-1:0] in_dir_x, in_dir_y, in_dir_z, norm_x, norm_y, norm_z;
  logic [vr_pkg::EW-1:0] eta_ratio;
  logic signed [vr_pkg::W-1:0] out_dir_x, out_dir_y, out_dir_z;

  dir_t pending_dirs[$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   sender_idle_pct = 38;

  vector_refraction i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- predictor ----------------
  // round to nearest, ties up: arithmetic shift gives the floor
  function automatic longint round_q(longint v);
    return (v + (ONE_Q >>> 1)) >>> vr_pkg::FRAC_BITS;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // floor integer square root, one result bit per pass
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic dir_t refract(ray_t r);
    longint d[3], n[3], p[3], q[3];
    longint dot_dn, cos_t, tang;
    longint unsigned len2, gap, root;
    dir_t res;
    d = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
    n = '{longint'(r.nx), longint'(r.ny), longint'(r.nz)};
    dot_dn = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    cos_t = round_q(-dot_dn);
    if (cos_t > ONE_Q) cos_t = ONE_Q;   // clamped above only
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      tang = d[i] + round_q(cos_t * n[i]);
      p[i] = sat(round_q(longint'({1'b0, r.eta}) * tang), -64'sd2147483648, 64'sd2147483647);
      len2 += longint'(p[i] * p[i]);      // wraps modulo 2^64 like the hardware
    end
    // total internal reflection is not flagged: root of the magnitude
    gap = (ONE_Q * ONE_Q >= len2) ? ONE_Q * ONE_Q - len2 : len2 - ONE_Q * ONE_Q;
    root = floor_sqrt(gap);
    for (int i = 0; i < 3; i++)
      q[i] = sat(p[i] - round_q(longint'(root) * n[i]), -(64'sd1 << (vr_pkg::W - 1)),
                 (64'sd1 << (vr_pkg::W - 1)) - 1);
    res.rx = q[0][vr_pkg::W-1:0];
    res.ry = q[1][vr_pkg::W-1:0];
    res.rz = q[2][vr_pkg::W-1:0];
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------
  // mostly near-unit components, sometimes any bit pattern at all
  function automatic logic signed [vr_pkg::W-1:0] rand_comp(bit wide);
    if (wide) return vr_pkg::W'($urandom);
    return vr_pkg::W'(int'($urandom_range(0, 2 * 65536)) - 65536);
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    bit wide;
    wide = ($urandom_range(0, 99) < 25);
    r.dx = rand_comp(wide);
    r.dy = rand_comp(wide);
    r.dz = rand_comp(wide);
    r.nx = rand_comp(wide);
    r.ny = rand_comp(wide);
    r.nz = rand_comp(wide);
    r.eta = wide ? vr_pkg::EW'($urandom) : vr_pkg::EW'($urandom_range(0, 2 * 65536));
    return r;
  endfunction

  // Drive one ray at the falling edge; hold it until a start transfer happens.
  // start stays high afterwards so the next ray can follow in the next cycle.
  task automatic send_ray(ray_t r, logic known, dir_t want);
    dir_t exp_dir;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    {in_dir_x, in_dir_y, in_dir_z, norm_x, norm_y, norm_z, eta_ratio} = r;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    exp_dir = refract(r);
    if (known && want !== exp_dir)
      $display("table row disagrees with predictor: %h vs %h", want, exp_dir);
    pending_dirs.push_back(known ? want : exp_dir);
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done) begin
        if (pending_dirs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with nothing expected");
        end else begin
          dir_t want;
          want = pending_dirs.pop_front();
          if (out_dir_x !== want.rx || out_dir_y !== want.ry || out_dir_z !== want.rz) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp (%0d %0d %0d) got (%0d %0d %0d)",
                       want.rx, want.ry, want.rz, out_dir_x, out_dir_y, out_dir_z);
          end
        end
      end
    end
  end

  // watchdog: nothing transferred for too long
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    row_t rows[$];
    localparam logic signed [vr_pkg::W-1:0] PONE = 21'sd65536;
    localparam logic signed [vr_pkg::W-1:0] NONE = -21'sd65536;
    localparam logic signed [vr_pkg::W-1:0] SMAX = 21'sd1048575;
    localparam logic signed [vr_pkg::W-1:0] SMIN = -21'sd1048576;

    start = 1'b0;
    {in_dir_x, in_dir_y, in_dir_z, norm_x, norm_y, norm_z, eta_ratio} = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // all zero: unit root times a zero normal
    rows.push_back('{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0}});
    // head-on ray through a matched interface goes straight down
    rows.push_back('{'{0, 0, NONE, 0, 0, PONE, 20'd65536}, 1'b1, '{0, 0, NONE}});
    // grazing, oblique, total internal reflection, head-on from behind
    rows.push_back('{'{PONE, 0, 0, 0, 0, PONE, 20'd65536}, 1'b0, '0});
    rows.push_back('{'{21'sd46341, 0, -21'sd46341, 0, 0, PONE, 20'd98304}, 1'b0, '0});
    rows.push_back('{'{21'sd46341, 0, -21'sd46341, 0, 0, PONE, 20'd43690}, 1'b0, '0});
    rows.push_back('{'{21'sd60000, 0, -21'sd26000, 0, 0, PONE, 20'd131072}, 1'b0, '0});
    rows.push_back('{'{0, 0, PONE, 0, 0, PONE, 20'd65536}, 1'b0, '0});
    // eta extremes
    rows.push_back('{'{21'sd30000, 21'sd20000, NONE, 0, PONE, 0, 20'd0}, 1'b0, '0});
    rows.push_back('{'{21'sd30000, 21'sd20000, NONE, 0, PONE, 0, 20'hFFFFF}, 1'b0, '0});
    // field extremes: saturation of the perpendicular part and the output
    rows.push_back('{'{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 20'hFFFFF}, 1'b0, '0});
    rows.push_back('{'{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 20'hFFFFF}, 1'b0, '0});
    rows.push_back('{'{SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 20'hFFFFF}, 1'b0, '0});
    rows.push_back('{'{SMIN, SMAX, SMIN, SMIN, SMAX, SMIN, 20'h00001}, 1'b0, '0});
    rows.push_back('{'{SMAX, 0, 0, SMIN, 0, 0, 20'hFFFFF}, 1'b0, '0});
    rows.push_back('{'{21'sd1, -21'sd1, 21'sd1, -21'sd1, 21'sd1, -21'sd1, 20'd1}, 1'b0, '0});
    // cosine of exactly +0.5 and -0.5
    rows.push_back('{'{21'sd32768, 0, 0, NONE, 0, 0, 20'd65536}, 1'b0, '0});
    rows.push_back('{'{-21'sd32768, 0, 0, NONE, 0, 0, 20'd65536}, 1'b0, '0});
    // non-unit normal, large negative cosine left unclamped
    rows.push_back('{'{SMAX, 0, 0, 21'sd200000, 0, 0, 20'd65536}, 1'b0, '0});

    foreach (rows[k]) send_ray(rows[k].ray, rows[k].known, rows[k].want);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 38 : ((phase == 1) ? 73 : 0);
      for (int k = 0; k < RANDOM_RAYS / 3; k++) send_ray(rand_ray(), 1'b0, '0);
      // after the first phase, hold off until the pipeline has fully drained
      if (phase == 0) begin
        @(negedge clk);
        start = 1'b0;
        wait (pending_dirs.size() == 0);
      end
    end

    @(negedge clk);
    start = 1'b0;
    wait (pending_dirs.size() == 0);
    repeat (vr_pkg::LAT + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+design
design/vr_pkg.sv
design/vr_front.sv
design/vr_sqrt.sv
design/vr_back.sv
design/vector_refraction.sv
design/vector_refraction_checker.sv
dv/vector_refraction_tb.sv
